// ===== rtl/tisd_pkg.sv =====
// Package with shared types, constants and helper functions of the sequence detector.
`timescale 1ns / 1ps

package tisd_pkg;

    localparam int CODE_W         = 6;
    localparam int CODES_PER_REG  = 4;
    localparam int CODES_W        = CODE_W * CODES_PER_REG;
    localparam int LEN_W          = 3;
    localparam int WIN_W          = 6;
    localparam int MAX_SEQ_LEN    = 4;
    localparam int SEQ_COUNT      = 2;
    localparam int NUM_CHECKED    = (SEQ_COUNT < 2) ? SEQ_COUNT : 2;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [CODES_W-1:0] t_codes;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [WIN_W-1:0]   t_win;
    typedef logic [2:0]         t_reg_idx;

    localparam t_reg_idx REG_SEQ0_CODES  = 3'd0;
    localparam t_reg_idx REG_SEQ1_CODES  = 3'd1;
    localparam t_reg_idx REG_SEQ0_LENGTH = 3'd2;
    localparam t_reg_idx REG_SEQ1_LENGTH = 3'd3;
    localparam t_reg_idx REG_SEQ0_WINDOW = 3'd4;
    localparam t_reg_idx REG_SEQ1_WINDOW = 3'd5;

    localparam t_codes RST_SEQ0_CODES  = 24'd8455428;
    localparam t_codes RST_SEQ1_CODES  = 24'd8470800;
    localparam t_len   RST_SEQ_LENGTH  = 3'd4;
    localparam t_win   RST_SEQ_WINDOW  = 6'd30;

    typedef struct packed {
        t_codes seq0_codes;
        t_codes seq1_codes;
        t_len   seq0_length;
        t_len   seq1_length;
        t_win   seq0_window;
        t_win   seq1_window;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CMP,
        ST_DONE
    } t_state;

    function automatic t_code encode_inputs(input logic up, input logic down,
                                            input logic left, input logic right,
                                            input logic fire);
        return {fire, right, left, down, up, 1'b0};
    endfunction

    function automatic t_code code_at(input t_codes codes, input t_len j);
        t_code r;
        unique case (j)
            3'd0:    r = codes[5:0];
            3'd1:    r = codes[11:6];
            3'd2:    r = codes[17:12];
            3'd3:    r = codes[23:18];
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tisd_if.sv =====
// Request channel interfaces for input samples and detection results.
`timescale 1ns / 1ps

interface tisd_in_if;
    logic valid;
    logic ready;
    logic stick_up;
    logic stick_down;
    logic stick_left;
    logic stick_right;
    logic fire_button;

    modport source (output valid, output stick_up, output stick_down, output stick_left,
                    output stick_right, output fire_button, input ready);
    modport sink (input valid, input stick_up, input stick_down, input stick_left,
                  input stick_right, input fire_button, output ready);
endinterface

interface tisd_out_if;
    logic valid;
    logic ready;
    logic fired_first;
    logic fired_second;

    modport source (output valid, output fired_first, output fired_second, input ready);
    modport sink (input valid, input fired_first, input fired_second, output ready);
endinterface

// ===== rtl/tisd_regs.sv =====
// APB configuration registers for the command codes, lengths and windows.
`timescale 1ns / 1ps

module tisd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tisd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tisd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tisd_pkg::APB_DATA_W-1:0] prdata,
    output logic                         pready,
    output tisd_pkg::t_cfg               o_cfg
);
    import tisd_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SEQ0_CODES:  n_cfg.seq0_codes  = pwdata[CODES_W-1:0];
                REG_SEQ1_CODES:  n_cfg.seq1_codes  = pwdata[CODES_W-1:0];
                REG_SEQ0_LENGTH: n_cfg.seq0_length = pwdata[LEN_W-1:0];
                REG_SEQ1_LENGTH: n_cfg.seq1_length = pwdata[LEN_W-1:0];
                REG_SEQ0_WINDOW: n_cfg.seq0_window = pwdata[WIN_W-1:0];
                REG_SEQ1_WINDOW: n_cfg.seq1_window = pwdata[WIN_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SEQ0_CODES:  prdata = APB_DATA_W'(r_cfg.seq0_codes);
            REG_SEQ1_CODES:  prdata = APB_DATA_W'(r_cfg.seq1_codes);
            REG_SEQ0_LENGTH: prdata = APB_DATA_W'(r_cfg.seq0_length);
            REG_SEQ1_LENGTH: prdata = APB_DATA_W'(r_cfg.seq1_length);
            REG_SEQ0_WINDOW: prdata = APB_DATA_W'(r_cfg.seq0_window);
            REG_SEQ1_WINDOW: prdata = APB_DATA_W'(r_cfg.seq1_window);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq0_codes  <= RST_SEQ0_CODES;
            r_cfg.seq1_codes  <= RST_SEQ1_CODES;
            r_cfg.seq0_length <= RST_SEQ_LENGTH;
            r_cfg.seq1_length <= RST_SEQ_LENGTH;
            r_cfg.seq0_window <= RST_SEQ_WINDOW;
            r_cfg.seq1_window <= RST_SEQ_WINDOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/tisd_hist_mem.sv =====
// History memory with one write port, one registered read port and per-entry valid bits.
`timescale 1ns / 1ps

module tisd_hist_mem #(
    parameter int HISTORY_DEPTH = 32,
    parameter int AW            = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  tisd_pkg::t_code      i_wdata,
    input  logic                 i_clear,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output tisd_pkg::t_code      o_rdata
);
    import tisd_pkg::*;

    t_code                    mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_valid;
    t_code                    r_rdata;
    logic                     r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== rtl/timed_input_sequence_detector_unit.sv =====
// Top level of the timed input sequence detector.
`timescale 1ns / 1ps

// Each accepted request packs the stick and button bits into a 6-bit code, stores it in a
// circular history and then checks command 0 and command 1 in turn, walking back from the
// newest entry through the command's window, one history entry compared per cycle on the
// single read port of the history memory. A match raises that command's flag and clears the
// whole history at once through per-entry valid bits, so no clearing pass is needed after
// reset or a match. A finished search is held while the previous result still waits to be
// taken. One result is returned for every request; the result register lets a new request
// enter while a result waits.
module timed_input_sequence_detector_unit #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tisd_in_if.sink                         i_in,
    tisd_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tisd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tisd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tisd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tisd_pkg::*;

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = (AW + 1 > WIN_W) ? AW + 1 : WIN_W;
    localparam logic [CW-1:0] DEPTH_CW = CW'(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_AW = (AW + 1)'(HISTORY_DEPTH);

    t_cfg          cfg;
    t_state        r_state, n_state;
    logic          r_cmd, n_cmd;
    logic [CW-1:0] r_i, n_i;
    t_len          r_j, n_j;
    logic [1:0]    r_fired, n_fired;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_flags, n_out_flags;

    t_codes        cur_codes;
    t_len          cur_len;
    t_win          cur_win;
    t_len          eff_len;
    logic [CW-1:0] eff_win;
    logic [CW-1:0] i_inc;
    logic          skip;
    logic          hit;
    logic          last_elem;
    logic          win_end;
    logic          cmd_done;
    logic          cmd_last;
    logic          out_free;
    logic          accept;
    t_code         rd_data;
    logic          mem_we;
    logic          mem_clear;
    logic          mem_re;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   pos_sum;

    tisd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tisd_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (encode_inputs(i_in.stick_up, i_in.stick_down, i_in.stick_left,
                                i_in.stick_right, i_in.fire_button)),
        .i_clear (mem_clear),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign accept    = i_in.valid && i_in.ready;
    assign cur_codes = r_cmd ? cfg.seq1_codes : cfg.seq0_codes;
    assign cur_len   = r_cmd ? cfg.seq1_length : cfg.seq0_length;
    assign cur_win   = r_cmd ? cfg.seq1_window : cfg.seq0_window;
    assign eff_len   = (cur_len > LEN_W'(MAX_SEQ_LEN)) ? LEN_W'(MAX_SEQ_LEN) : cur_len;
    assign eff_win   = (CW'(cur_win) > DEPTH_CW) ? DEPTH_CW : CW'(cur_win);
    assign skip      = (eff_len == '0) || (eff_win == '0);
    assign i_inc     = r_i + CW'(1);
    assign hit       = (rd_data == code_at(cur_codes, r_j));
    assign last_elem = (r_j == '0);
    assign win_end   = (i_inc >= eff_win);
    assign cmd_last  = (r_cmd == 1'(NUM_CHECKED - 1));
    assign out_free  = !r_out_valid || o_out.ready;
    assign cmd_done  = ((r_state == ST_START) && skip) ||
                       ((r_state == ST_CMP) && ((hit && last_elem) || (!hit && win_end)));

    assign pos_sum = {1'b0, r_wp} + DEPTH_AW - {1'b0, n_i[AW-1:0]};
    assign rd_addr = (pos_sum >= DEPTH_AW) ? AW'(pos_sum - DEPTH_AW) : pos_sum[AW-1:0];

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.fired_first  = r_out_flags[0];
    assign o_out.fired_second = r_out_flags[1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (skip) begin
                    n_state = cmd_last ? ST_DONE : ST_START;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (cmd_done) begin
                    n_state = cmd_last ? ST_DONE : ST_START;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_i         = r_i;
        n_j         = r_j;
        n_fired     = r_fired;
        n_wp        = r_wp;
        n_out_valid = r_out_valid;
        n_out_flags = r_out_flags;
        mem_we      = 1'b0;
        mem_clear   = 1'b0;
        mem_re      = 1'b0;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    mem_we  = 1'b1;
                    n_cmd   = 1'b0;
                    n_fired = '0;
                end
            end
            ST_START: begin
                n_i    = '0;
                n_j    = eff_len - LEN_W'(1);
                mem_re = 1'b1;
            end
            ST_CMP: begin
                mem_re = 1'b1;
                if (hit) begin
                    if (last_elem) begin
                        n_fired[r_cmd] = 1'b1;
                        mem_clear      = 1'b1;
                    end else begin
                        n_j = r_j - LEN_W'(1);
                    end
                end else begin
                    n_i = i_inc;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_flags = r_fired;
                    n_wp        = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                end
            end
            default: begin
                n_cmd = r_cmd;
            end
        endcase
        if (cmd_done && !cmd_last) begin
            n_cmd = r_cmd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd       <= 1'b0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_fired     <= n_fired;
        r_out_flags <= n_out_flags;
    end

endmodule

// ===== rtl/tisd_checker.sv =====
// Port-level checker for the sequence detector and its bind to the top level.
`timescale 1ns / 1ps

module tisd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_fired_first,
    input logic i_fired_second
);

    // A request is searched to the end before the next one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while a search is still running");

    // A result is only set from the done state, so no result follows a request at once.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared directly after a request");

    // A waiting result holds its flags until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_fired_first) && $stable(i_fired_second))
        else $error("waiting result changed before it was taken");

endmodule

bind timed_input_sequence_detector_unit tisd_checker u_tisd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_fired_first  (o_out.fired_first),
    .i_fired_second (o_out.fired_second)
);

// ===== dv/timed_input_sequence_detector_unit_tb.sv =====
// Self-checking testbench of the timed input sequence detector with APB setup and random traffic.
`timescale 1ns / 1ps

module timed_input_sequence_detector_unit_tb;

    import tisd_pkg::*;

    localparam int HISTORY_DEPTH = 32;
    localparam int CYCLE_LIMIT   = 1_500_000;

    typedef struct packed {
        logic first;
        logic second;
    } t_fire_flags;

    class fire_scoreboard;
        t_code       history [HISTORY_DEPTH];
        int          wr_pos;
        t_codes      seq_codes [2];
        t_len        seq_len [2];
        t_win        seq_win [2];
        t_fire_flags pending_fires [$];
        int          mismatches;

        function new();
            foreach (history[k]) history[k] = '0;
            wr_pos       = 0;
            seq_codes[0] = RST_SEQ0_CODES;
            seq_codes[1] = RST_SEQ1_CODES;
            seq_len[0]   = RST_SEQ_LENGTH;
            seq_len[1]   = RST_SEQ_LENGTH;
            seq_win[0]   = RST_SEQ_WINDOW;
            seq_win[1]   = RST_SEQ_WINDOW;
            mismatches   = 0;
        endfunction

        function void note_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
            end
        endfunction

        function void write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_SEQ0_CODES:  seq_codes[0] = value[CODES_W-1:0];
                REG_SEQ1_CODES:  seq_codes[1] = value[CODES_W-1:0];
                REG_SEQ0_LENGTH: seq_len[0]   = value[LEN_W-1:0];
                REG_SEQ1_LENGTH: seq_len[1]   = value[LEN_W-1:0];
                REG_SEQ0_WINDOW: seq_win[0]   = value[WIN_W-1:0];
                REG_SEQ1_WINDOW: seq_win[1]   = value[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [APB_DATA_W-1:0] reg_value(t_reg_idx idx);
            logic [APB_DATA_W-1:0] v;
            v = '0;
            case (idx)
                REG_SEQ0_CODES:  v[CODES_W-1:0] = seq_codes[0];
                REG_SEQ1_CODES:  v[CODES_W-1:0] = seq_codes[1];
                REG_SEQ0_LENGTH: v[LEN_W-1:0]   = seq_len[0];
                REG_SEQ1_LENGTH: v[LEN_W-1:0]   = seq_len[1];
                REG_SEQ0_WINDOW: v[WIN_W-1:0]   = seq_win[0];
                REG_SEQ1_WINDOW: v[WIN_W-1:0]   = seq_win[1];
                default: ;
            endcase
            return v;
        endfunction

        // Walks back from the newest entry; each element resumes where the previous one hit.
        function bit command_hits(int c);
            int    n;
            int    w;
            int    i;
            int    pos;
            t_code want;
            n = seq_len[c];
            w = seq_win[c];
            if (n == 0 || w == 0) return 1'b0;
            if (n > MAX_SEQ_LEN) n = MAX_SEQ_LEN;
            if (w > HISTORY_DEPTH) w = HISTORY_DEPTH;
            i = 0;
            for (int j = n; j > 0; j--) begin
                want = seq_codes[c][CODE_W*(j-1) +: CODE_W];
                while (i < w) begin
                    pos = (wr_pos + HISTORY_DEPTH - i) % HISTORY_DEPTH;
                    if (history[pos] == want) break;
                    i++;
                end
                if (i >= w) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(logic [4:0] sticks);
            t_fire_flags f;
            history[wr_pos] = {sticks, 1'b0};
            f.first = command_hits(0);
            if (f.first) foreach (history[k]) history[k] = '0;
            f.second = command_hits(1);
            if (f.second) foreach (history[k]) history[k] = '0;
            wr_pos = (wr_pos + 1) % HISTORY_DEPTH;
            pending_fires.push_back(f);
        endfunction

        function void check_result(logic fired_first, logic fired_second);
            t_fire_flags f;
            if (pending_fires.size() == 0) begin
                note_mismatch("result without request", 0, {fired_first, fired_second});
                return;
            end
            f = pending_fires.pop_front();
            if (fired_first !== f.first) note_mismatch("fired_first", f.first, fired_first);
            if (fired_second !== f.second) note_mismatch("fired_second", f.second, fired_second);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tisd_in_if  in_if ();
    tisd_out_if out_if ();

    fire_scoreboard sb;
    int             cycle_count;
    int             src_run;
    bit             src_quiet;
    int             snk_run;
    bit             snk_quiet;

    timed_input_sequence_detector_unit #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_request({in_if.fire_button, in_if.stick_right, in_if.stick_left,
                                 in_if.stick_down, in_if.stick_up});
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.fired_first, out_if.fired_second);
            end
        end
    end

    // Mostly short gaps, a few long ones, and quiet stretches with none at all.
    function automatic int next_gap(inout int run_left, inout bit quiet);
        int r;
        if (run_left == 0) begin
            run_left = $urandom_range(20, 80);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [4:0] sticks);
        int gap;
        gap = next_gap(src_run, src_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {in_if.fire_button, in_if.stick_right, in_if.stick_left,
         in_if.stick_down, in_if.stick_up} = sticks;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(idx * 4);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic void note_readback(t_reg_idx idx, logic [APB_DATA_W-1:0] got);
        sb.note_mismatch($sformatf("register %0d readback", idx), sb.reg_value(idx), got);
    endfunction

    task automatic apb_check(input t_reg_idx idx);
        logic [APB_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = APB_ADDR_W'(idx * 4);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== sb.reg_value(idx)) note_readback(idx, got);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_config(input t_codes c0, input t_codes c1, input t_len l0,
                                  input t_len l1, input t_win w0, input t_win w1);
        apb_write(REG_SEQ0_CODES, APB_DATA_W'(c0));
        apb_write(REG_SEQ1_CODES, APB_DATA_W'(c1));
        apb_write(REG_SEQ0_LENGTH, APB_DATA_W'(l0));
        apb_write(REG_SEQ1_LENGTH, APB_DATA_W'(l1));
        apb_write(REG_SEQ0_WINDOW, APB_DATA_W'(w0));
        apb_write(REG_SEQ1_WINDOW, APB_DATA_W'(w1));
        for (int k = 0; k < 6; k++) apb_check(t_reg_idx'(k));
    endtask

    // Command codes drawn so that repeated entries and odd codes both turn up.
    function automatic t_codes make_codes();
        t_codes v;
        int     r;
        v = '0;
        for (int j = 0; j < CODES_PER_REG; j++) begin
            r = $urandom_range(0, 9);
            if (r < 2 && j > 0) v[CODE_W*j +: CODE_W] = v[CODE_W*(j-1) +: CODE_W];
            else if (r == 9) v[CODE_W*j +: CODE_W] = CODE_W'($urandom_range(0, 63));
            else v[CODE_W*j +: CODE_W] = {5'($urandom_range(0, 31)), 1'b0};
        end
        return v;
    endfunction

    function automatic t_len pick_len();
        if ($urandom_range(0, 4) != 0) return t_len'($urandom_range(1, MAX_SEQ_LEN));
        return t_len'($urandom_range(0, 7));
    endfunction

    function automatic t_win pick_win();
        if ($urandom_range(0, 9) < 7) return t_win'($urandom_range(1, HISTORY_DEPTH));
        if ($urandom_range(0, 2) == 0) return '0;
        return t_win'($urandom_range(HISTORY_DEPTH + 1, 63));
    endfunction

    // Plays command c element by element, optionally with noise between and one element left out.
    task automatic feed_command(input int c, input bit noisy, input int skip, output int n_sent);
        int n;
        n      = (sb.seq_len[c] == 0) ? 1 : sb.seq_len[c];
        n      = (n > MAX_SEQ_LEN) ? MAX_SEQ_LEN : n;
        n_sent = 0;
        for (int j = 0; j < n; j++) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(5'($urandom_range(0, 31)));
                    n_sent++;
                end
            end
            if (j != skip) begin
                send_request(sb.seq_codes[c][CODE_W*j+1 +: 5]);
                n_sent++;
            end
        end
    endtask

    task automatic run_random(input int n_items);
        int sent;
        int r;
        int k;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                feed_command($urandom_range(0, 1), 1'b1, -1, k);
            end else if (r < 85) begin
                feed_command($urandom_range(0, 1), 1'b1, $urandom_range(0, MAX_SEQ_LEN - 1), k);
            end else begin
                k = $urandom_range(1, 4);
                repeat (k) send_request(5'($urandom_range(0, 31)));
            end
            sent += k;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending_fires.size() != 0) @(posedge i_clk);
    endtask

    task automatic ready_init();
        int gap;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = next_gap(snk_run, snk_quiet);
            @(negedge i_clk);
            if (gap > 0) begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    endtask

    initial begin
        ready_init();
    end

    initial begin
        int k;
        int settle;
        sb                = new();
        cycle_count       = 0;
        src_run           = 0;
        src_quiet         = 1'b0;
        snk_run           = 0;
        snk_quiet         = 1'b0;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.stick_up    = 1'b0;
        in_if.stick_down  = 1'b0;
        in_if.stick_left  = 1'b0;
        in_if.stick_right = 1'b0;
        in_if.fire_button = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: readback, field extremes, each input bit alone, commands, traffic.
        for (int r = 0; r < 6; r++) apb_check(t_reg_idx'(r));
        send_request(5'h00);
        send_request(5'h1f);
        for (int b = 0; b < 5; b++) send_request(5'(1 << b));
        feed_command(0, 1'b0, -1, k);
        feed_command(1, 1'b0, -1, k);
        feed_command(0, 1'b1, -1, k);
        feed_command(1, 1'b0, 1, k);
        run_random(180);
        drain();

        for (int ph = 1; ph <= 8; ph++) begin
            case (ph)
                1: program_config(make_codes(), make_codes(), 3'd1, 3'd4, 6'd1, 6'd32);
                2: program_config(24'hffffff, 24'h000000, 3'd0, 3'd7, 6'd63, 6'd0);
                3: program_config(24'h000000, make_codes(), 3'd2, 3'd3, 6'd5, 6'd20);
                4: program_config(make_codes(), make_codes(), 3'd5, 3'd6, 6'd40, 6'd32);
                5: program_config(make_codes(), make_codes(), 3'd4, 3'd2, 6'd4, 6'd3);
                default: program_config(make_codes(), make_codes(), pick_len(), pick_len(),
                                        pick_win(), pick_win());
            endcase
            run_random((ph == 2 || ph == 3) ? 50 : 200);
            drain();
        end

        settle = 0;
        while (settle < 100) begin
            @(posedge i_clk);
            settle++;
        end
        if (sb.mismatches == 0 && sb.pending_fires.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tisd_pkg.sv
rtl/tisd_if.sv
rtl/tisd_regs.sv
rtl/tisd_hist_mem.sv
rtl/timed_input_sequence_detector_unit.sv
rtl/tisd_checker.sv
dv/timed_input_sequence_detector_unit_tb.sv
